// File: rtl/hbs_pkg.sv
// ---------------------------------------------------------------------------
// hbs_pkg
// Shared sizes and codes of the heightmap bilinear sampler.
// ---------------------------------------------------------------------------
`default_nettype none

package hbs_pkg;

    // Grid size; both dimensions are powers of two, so row*MAP_W+col is exact
    localparam int MAP_W      = 512;
    localparam int MAP_H      = 512;
    localparam int COL_W      = $clog2(MAP_W);
    localparam int ROW_W      = $clog2(MAP_H);
    localparam int IDX_W      = (COL_W > ROW_W) ? COL_W : ROW_W;
    localparam int ADDR_W     = COL_W + ROW_W;

    // Four banks by row and column parity
    localparam int NUM_BANKS  = 4;
    localparam int BANK_AW    = ADDR_W - 2;
    localparam int BANK_DEPTH = (MAP_W * MAP_H) / NUM_BANKS;

    // Field widths
    localparam int HGT_W      = 16;
    localparam int POS_W      = 32;
    localparam int GAIN_W     = 31;
    localparam int CFG_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int FRAC_W     = 16;
    localparam int CELL_W     = POS_W + 1 - FRAC_W;

    localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(65536);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORIGIN_X = 2'd0,
        CFG_ORIGIN_Y = 2'd1,
        CFG_ORIGIN_Z = 2'd2,
        CFG_GAIN     = 2'd3
    } t_cfg_idx;

    typedef enum logic {
        CMD_LOAD  = 1'b0,
        CMD_QUERY = 1'b1
    } t_cmd;

    // One axis of a query after the cell split and clamp
    typedef struct packed {
        logic [IDX_W-1:0]  c0;
        logic [IDX_W-1:0]  c1;
        logic [FRAC_W-1:0] frac;
        logic              off;
    } t_axis;

endpackage

`default_nettype wire

// File: rtl/hbs_ram.sv
// ---------------------------------------------------------------------------
// hbs_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module hbs_ram #(
    parameter int DEPTH = 65536,
    parameter int AW    = 16,
    parameter int DW    = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; data holds while read enable is low
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: rtl/heightmap_bilinear_sampler.sv
// A query passes the bank read, y lerp, x lerp, gain and output registers in order.
// Throughput: one transaction per cycle while the skid stage is empty, loads and queries
// mixed freely; each query reads its four corners together from four parity banks.
// Loads return nothing and write their bank at the acceptance edge.
// Reset (synchronous, active low) clears the pipeline valids, the output and skid
// valids and the configuration registers; the height grid is not cleared.
// ---------------------------------------------------------------------------
// heightmap_bilinear_sampler
// Stores a height grid and projects query positions onto it by bilinear
// interpolation, gain scaling and origin offset.
// ---------------------------------------------------------------------------
`default_nettype none

module heightmap_bilinear_sampler (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // configuration
    input  wire logic                                i_cfg_we,
    input  wire logic [hbs_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire logic [hbs_pkg::CFG_W-1:0]           i_cfg_data,
    // input channel
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire logic                                i_cmd,
    input  wire logic [hbs_pkg::ADDR_W-1:0]          i_cell_addr,
    input  wire logic [hbs_pkg::HGT_W-1:0]           i_height_value,
    input  wire logic signed [hbs_pkg::POS_W-1:0]    i_pos_x,
    input  wire logic signed [hbs_pkg::POS_W-1:0]    i_pos_y,
    // output channel
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic signed [hbs_pkg::POS_W-1:0]         o_proj_x,
    output logic signed [hbs_pkg::POS_W-1:0]         o_proj_y,
    output logic signed [hbs_pkg::POS_W-1:0]         o_proj_z,
    output logic                                     o_off_map
);

    localparam int PW = hbs_pkg::POS_W;
    localparam int HW = hbs_pkg::HGT_W;
    localparam int FW = hbs_pkg::FRAC_W;
    localparam int GW = hbs_pkg::GAIN_W;
    localparam int CW = hbs_pkg::CELL_W;
    localparam int XW = hbs_pkg::IDX_W;
    localparam int PROD_W = HW + GW;

    // Split an origin-relative coordinate into clamped cell pair and fraction
    function automatic hbs_pkg::t_axis split_axis(input logic signed [PW:0] d,
                                                  input logic [XW-1:0] cmax);
        logic signed [CW-1:0] c;
        logic                 neg;
        logic                 high;
        hbs_pkg::t_axis       a;
        c      = d[PW:FW];
        neg    = c[CW-1];
        high   = !neg && (c >= $signed(CW'(cmax)));
        a.frac = d[FW-1:0];
        a.off  = neg || high;
        if (neg) begin
            a.c0 = '0;
            a.c1 = '0;
        end else if (high) begin
            a.c0 = cmax;
            a.c1 = cmax;
        end else begin
            a.c0 = c[XW-1:0];
            a.c1 = c[XW-1:0] + XW'(1);
        end
        return a;
    endfunction

    // a + ((b - a) * f) >>> 16, equal to (a*(65536-f) + b*f) >> 16
    function automatic logic [HW-1:0] lerp16(input logic [HW-1:0] a,
                                             input logic [HW-1:0] b,
                                             input logic [FW-1:0] f);
        logic signed [HW:0]       diff;
        logic signed [HW+FW+1:0]  prod;
        logic signed [HW+1:0]     sum;
        diff = $signed({1'b0, b}) - $signed({1'b0, a});
        prod = diff * $signed({1'b0, f});
        sum  = $signed({2'b00, a}) + $signed(prod[HW+FW+1:FW]);
        return sum[HW-1:0];
    endfunction

    // -----------------------------------------------------------------------
    // Configuration registers
    // -----------------------------------------------------------------------
    logic signed [PW-1:0] r_org_x;
    logic signed [PW-1:0] r_org_y;
    logic signed [PW-1:0] r_org_z;
    logic        [GW-1:0] r_gain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org_x <= '0;
            r_org_y <= '0;
            r_org_z <= '0;
            r_gain  <= hbs_pkg::GAIN_RESET;
        end else if (i_cfg_we) begin
            case (hbs_pkg::t_cfg_idx'(i_cfg_idx))
                hbs_pkg::CFG_ORIGIN_X: r_org_x <= i_cfg_data;
                hbs_pkg::CFG_ORIGIN_Y: r_org_y <= i_cfg_data;
                hbs_pkg::CFG_ORIGIN_Z: r_org_z <= i_cfg_data;
                hbs_pkg::CFG_GAIN:     r_gain  <= i_cfg_data[GW-1:0];
                default: ;
            endcase
        end
    end

    // -----------------------------------------------------------------------
    // Handshake: the whole pipeline advances while the skid stage is empty
    // -----------------------------------------------------------------------
    logic r_skid_valid;
    logic w_en;
    logic w_acc;
    logic w_query;
    logic w_load;

    assign w_en       = !r_skid_valid;
    assign o_in_ready = w_en;
    assign w_acc      = i_in_valid && w_en;
    assign w_query    = w_acc && (hbs_pkg::t_cmd'(i_cmd) == hbs_pkg::CMD_QUERY);
    assign w_load     = w_acc && (hbs_pkg::t_cmd'(i_cmd) == hbs_pkg::CMD_LOAD);

    // -----------------------------------------------------------------------
    // Address stage: origin subtract, cell split, bank addresses
    // -----------------------------------------------------------------------
    logic signed [PW:0] w_dx;
    logic signed [PW:0] w_dy;
    hbs_pkg::t_axis     w_ax;
    hbs_pkg::t_axis     w_ay;

    assign w_dx = $signed({i_pos_x[PW-1], i_pos_x}) - $signed({r_org_x[PW-1], r_org_x});
    assign w_dy = $signed({i_pos_y[PW-1], i_pos_y}) - $signed({r_org_y[PW-1], r_org_y});
    assign w_ax = split_axis(w_dx, XW'(hbs_pkg::MAP_W - 1));
    assign w_ay = split_axis(w_dy, XW'(hbs_pkg::MAP_H - 1));

    logic [HW-1:0] w_q [hbs_pkg::NUM_BANKS];

    // One bank per (row parity, column parity); each corner pair hits distinct banks
    for (genvar b = 0; b < hbs_pkg::NUM_BANKS; b++) begin : g_bank
        localparam logic RP = (b >= 2);
        localparam logic CP = ((b % 2) == 1);
        logic [XW-1:0]                  w_row;
        logic [XW-1:0]                  w_col;
        logic [hbs_pkg::BANK_AW-1:0]    w_raddr;
        logic [hbs_pkg::BANK_AW-1:0]    w_waddr;
        logic                           w_we;

        assign w_row   = (w_ay.c0[0] == RP) ? w_ay.c0 : w_ay.c1;
        assign w_col   = (w_ax.c0[0] == CP) ? w_ax.c0 : w_ax.c1;
        assign w_raddr = {w_row[hbs_pkg::ROW_W-1:1], w_col[hbs_pkg::COL_W-1:1]};
        assign w_waddr = {i_cell_addr[hbs_pkg::ADDR_W-1:hbs_pkg::COL_W+1],
                          i_cell_addr[hbs_pkg::COL_W-1:1]};
        assign w_we    = w_load && (i_cell_addr[hbs_pkg::COL_W] == RP)
                                && (i_cell_addr[0] == CP);

        hbs_ram #(
            .DEPTH (hbs_pkg::BANK_DEPTH),
            .AW    (hbs_pkg::BANK_AW),
            .DW    (HW)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (w_we),
            .i_waddr (w_waddr),
            .i_wdata (i_height_value),
            .i_re    (w_en),
            .i_raddr (w_raddr),
            .o_rdata (w_q[b])
        );
    end

    // -----------------------------------------------------------------------
    // Pipeline valids
    // -----------------------------------------------------------------------
    logic r_v1, r_v2, r_v3, r_v4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= w_query;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    // -----------------------------------------------------------------------
    // Payload stages
    // -----------------------------------------------------------------------
    logic signed [PW-1:0] r_px1, r_px2, r_px3, r_px4;
    logic signed [PW-1:0] r_py1, r_py2, r_py3, r_py4;
    logic                 r_off1, r_off2, r_off3, r_off4;
    logic [FW-1:0]        r_fx1, r_fx2;
    logic [FW-1:0]        r_fy1;
    logic                 r_x0p, r_x1p, r_y0p, r_y1p;
    logic [HW-1:0]        r_w1, r_w2;
    logic [HW-1:0]        r_w;
    logic [GW-1:0]        r_scaled;

    // Select corners by parity of the cell indices
    logic [HW-1:0]     w_h00, w_h01, w_h10, w_h11;
    logic [PROD_W-1:0] w_prod;

    assign w_h00  = w_q[{r_y0p, r_x0p}];
    assign w_h01  = w_q[{r_y1p, r_x0p}];
    assign w_h10  = w_q[{r_y0p, r_x1p}];
    assign w_h11  = w_q[{r_y1p, r_x1p}];
    assign w_prod = {{GW{1'b0}}, r_w} * {{HW{1'b0}}, r_gain};

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            // capture query fields alongside the bank reads
            r_px1  <= i_pos_x;
            r_py1  <= i_pos_y;
            r_off1 <= w_ax.off || w_ay.off;
            r_fx1  <= w_ax.frac;
            r_fy1  <= w_ay.frac;
            r_x0p  <= w_ax.c0[0];
            r_x1p  <= w_ax.c1[0];
            r_y0p  <= w_ay.c0[0];
            r_y1p  <= w_ay.c1[0];
            // interpolate along y
            r_px2  <= r_px1;
            r_py2  <= r_py1;
            r_off2 <= r_off1;
            r_fx2  <= r_fx1;
            r_w1   <= lerp16(w_h00, w_h01, r_fy1);
            r_w2   <= lerp16(w_h10, w_h11, r_fy1);
            // interpolate along x
            r_px3  <= r_px2;
            r_py3  <= r_py2;
            r_off3 <= r_off2;
            r_w    <= lerp16(r_w1, r_w2, r_fx2);
            // apply gain
            r_px4    <= r_px3;
            r_py4    <= r_py3;
            r_off4   <= r_off3;
            r_scaled <= w_prod[PROD_W-1:FW];
        end
    end

    // Add origin z and saturate; the scaled height is never negative
    logic signed [PW:0]   w_sum;
    logic signed [PW-1:0] w_z;

    assign w_sum = $signed({r_org_z[PW-1], r_org_z}) + $signed({2'b00, r_scaled});
    assign w_z   = (w_sum[PW] != w_sum[PW-1]) ? {1'b0, {(PW-1){1'b1}}} : w_sum[PW-1:0];

    // -----------------------------------------------------------------------
    // Output register and skid stage
    // -----------------------------------------------------------------------
    logic                 r_out_valid;
    logic signed [PW-1:0] r_out_x, r_out_y, r_out_z;
    logic                 r_out_off;
    logic signed [PW-1:0] r_skid_x, r_skid_y, r_skid_z;
    logic                 r_skid_off;
    logic                 w_push;
    logic                 w_out_free;

    assign w_push     = w_en && r_v4;
    assign w_out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid  <= r_skid_valid || w_push;
            r_skid_valid <= 1'b0;
        end else if (w_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            // drain the skid first, else take the new result
            if (r_skid_valid) begin
                r_out_x   <= r_skid_x;
                r_out_y   <= r_skid_y;
                r_out_z   <= r_skid_z;
                r_out_off <= r_skid_off;
            end else begin
                r_out_x   <= r_px4;
                r_out_y   <= r_py4;
                r_out_z   <= w_z;
                r_out_off <= r_off4;
            end
        end else if (w_push) begin
            // park the result while the output stalls
            r_skid_x   <= r_px4;
            r_skid_y   <= r_py4;
            r_skid_z   <= w_z;
            r_skid_off <= r_off4;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_proj_x    = r_out_x;
    assign o_proj_y    = r_out_y;
    assign o_proj_z    = r_out_z;
    assign o_off_map   = r_out_off;

endmodule

`default_nettype wire

// File: rtl/hbs_checker.sv
// ---------------------------------------------------------------------------
// hbs_checker
// Port-level checks of the heightmap bilinear sampler, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module hbs_checker (
    input wire logic                               i_clk,
    input wire logic                               i_rst_n,
    input wire logic                               o_in_ready,
    input wire logic                               o_out_valid,
    input wire logic                               i_out_ready,
    input wire logic signed [hbs_pkg::POS_W-1:0]   o_proj_x,
    input wire logic signed [hbs_pkg::POS_W-1:0]   o_proj_y,
    input wire logic signed [hbs_pkg::POS_W-1:0]   o_proj_z,
    input wire logic                               o_off_map
);

    // Reset empties the output and opens the input
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("output valid or input stall after reset");

    // Hold a stalled result transaction
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_proj_x)
            && $stable(o_proj_y) && $stable(o_proj_z) && $stable(o_off_map))
        else $error("stalled result changed or dropped");

    // Stall the input only after the output stalled
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> $past(o_out_valid && !i_out_ready))
        else $error("input stalled without output back-pressure");

    // Drain the skid stage into the output in the cycle after the output is taken
    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_in_ready |=> o_out_valid && o_in_ready)
        else $error("parked result lost or input still stalled");

endmodule

bind heightmap_bilinear_sampler hbs_checker u_hbs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_proj_x    (o_proj_x),
    .o_proj_y    (o_proj_y),
    .o_proj_z    (o_proj_z),
    .o_off_map   (o_off_map)
);

`default_nettype wire
